// ----- rtl/bse_pkg.sv -----
// Package for the streaming base32 encoder.
// Holds the job descriptor passed from front to back, opcodes, register
// indexes and reset values. No dependencies.
package bse_pkg;

  localparam int unsigned CFG_W      = 40;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned REG6_W     = 24;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QAW        = 2;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CHARS_0_4   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_5_9   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_10_14 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_15_19 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_20_24 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_25_29 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_30_32 = 3'd6;

  localparam logic [CFG_W-1:0]  RST_CHARS_0_4   = 40'd297498001985;
  localparam logic [CFG_W-1:0]  RST_CHARS_5_9   = 40'd319057053510;
  localparam logic [CFG_W-1:0]  RST_CHARS_10_14 = 40'd340616105035;
  localparam logic [CFG_W-1:0]  RST_CHARS_15_19 = 40'd362175156560;
  localparam logic [CFG_W-1:0]  RST_CHARS_20_24 = 40'd383734208085;
  localparam logic [CFG_W-1:0]  RST_CHARS_25_29 = 40'd228509037146;
  localparam logic [REG6_W-1:0] RST_CHARS_30_32 = 24'd4011830;

  localparam logic [5:0] PAD_IDX = 6'd32;

  // One accepted input item as work for the back end: up to two
  // alphabet lookups followed by up to six pad characters.
  typedef struct packed {
    logic [4:0] v0;
    logic [4:0] v1;
    logic       two;
    logic [2:0] pads;
  } job_t;

endpackage

// ----- rtl/base32_stream_encoder_top.sv -----
// Streaming base32 encoder, top level. Instantiates bse_front, bse_fifo
// and bse_back; depends on bse_pkg.
// Path of an item: job queue, back end job register, output register.
// Throughput: one character per cycle at the output register unless
// out_stall holds it; one or two per data byte, up to seven per finish.
// Reset (rst, synchronous): phase and leftover cleared, queue emptied,
// alphabet restored to the standard set with pad '='.
module base32_stream_encoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [7:0]                     data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     code_char,
  output logic                           last_char,
  input  logic                           cfg_we,
  input  logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bse_pkg::CFG_W-1:0]      cfg_data
);
  import bse_pkg::*;

  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic full;
  logic not_empty;

  bse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .data_byte (data_byte),
    .q_full    (full),
    .q_push    (push),
    .q_job     (push_job)
  );

  bse_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .not_empty (not_empty)
  );

  bse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (not_empty),
    .q_head      (head),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_char   (code_char),
    .last_char   (last_char)
  );

endmodule

// ----- rtl/bse_front.sv -----
// Front end of the base32 encoder: accepts items, tracks group phase and
// leftover bits, and turns each item into a job. Depends on bse_pkg.
module bse_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          opcode,
  input  logic [7:0]    data_byte,
  input  logic          q_full,
  output logic          q_push,
  output bse_pkg::job_t q_job
);
  import bse_pkg::*;

  localparam logic [2:0] PH0 = 3'd0;
  localparam logic [2:0] PH1 = 3'd1;
  localparam logic [2:0] PH2 = 3'd2;
  localparam logic [2:0] PH3 = 3'd3;
  localparam logic [2:0] PH4 = 3'd4;

  logic [2:0] phase, phase_next;
  logic [4:0] leftover, leftover_next;
  logic       accept;
  logic       emits;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && emits;

  always_comb begin
    phase_next    = PH0;
    leftover_next = 5'd0;
    q_job         = '0;
    emits         = 1'b1;
    if (opcode == OP_ENCODE) begin
      unique case (phase)
        PH1: begin
          q_job.v0      = leftover | {3'b0, data_byte[7:6]};
          q_job.v1      = data_byte[5:1];
          q_job.two     = 1'b1;
          leftover_next = {data_byte[0], 4'b0};
          phase_next    = PH2;
        end
        PH2: begin
          q_job.v0      = leftover | {1'b0, data_byte[7:4]};
          leftover_next = {data_byte[3:0], 1'b0};
          phase_next    = PH3;
        end
        PH3: begin
          q_job.v0      = leftover | {4'b0, data_byte[7]};
          q_job.v1      = data_byte[6:2];
          q_job.two     = 1'b1;
          leftover_next = {data_byte[1:0], 3'b0};
          phase_next    = PH4;
        end
        PH4: begin
          q_job.v0  = leftover | {2'b0, data_byte[7:5]};
          q_job.v1  = data_byte[4:0];
          q_job.two = 1'b1;
        end
        default: begin
          q_job.v0      = data_byte[7:3];
          leftover_next = {data_byte[2:0], 2'b0};
          phase_next    = PH1;
        end
      endcase
    end else begin
      q_job.v0 = leftover;
      unique case (phase)
        PH1:     q_job.pads = 3'd6;
        PH2:     q_job.pads = 3'd4;
        PH3:     q_job.pads = 3'd3;
        PH4:     q_job.pads = 3'd1;
        default: emits = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH0;
      leftover <= 5'd0;
    end else if (accept) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

// ----- rtl/bse_fifo.sv -----
// Short job queue between front and back ends of the base32 encoder.
// Depends on bse_pkg for the job type and depth.
module bse_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bse_pkg::job_t push_job,
  input  logic          pop,
  output bse_pkg::job_t head,
  output logic          full,
  output logic          not_empty
);
  import bse_pkg::*;

  job_t         entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full      = (count == QDEPTH[QAW:0]);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("job queue written while full");

endmodule

// ----- rtl/bse_back.sv -----
// Back end of the base32 encoder: holds the alphabet registers, walks each
// job one character per cycle unless out_stall holds it, and drives the
// output register. Depends on bse_pkg.
module bse_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bse_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           q_not_empty,
  input  bse_pkg::job_t                  q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     code_char,
  output logic                           last_char
);
  import bse_pkg::*;

  localparam logic [1:0] ST_V0  = 2'd0;
  localparam logic [1:0] ST_V1  = 2'd1;
  localparam logic [1:0] ST_PAD = 2'd2;

  logic [CFG_W-1:0]  chars_0_4, chars_5_9, chars_10_14, chars_15_19;
  logic [CFG_W-1:0]  chars_20_24, chars_25_29;
  logic [REG6_W-1:0] chars_30_32;
  logic [263:0]      alphabet;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] stage, stage_next;
  logic [2:0] pads_left, pads_left_next;
  logic       load_out;
  logic       is_last;
  logic       done;
  logic [5:0] char_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_0_4   <= RST_CHARS_0_4;
      chars_5_9   <= RST_CHARS_5_9;
      chars_10_14 <= RST_CHARS_10_14;
      chars_15_19 <= RST_CHARS_15_19;
      chars_20_24 <= RST_CHARS_20_24;
      chars_25_29 <= RST_CHARS_25_29;
      chars_30_32 <= RST_CHARS_30_32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHARS_0_4:   chars_0_4   <= cfg_data;
        REG_CHARS_5_9:   chars_5_9   <= cfg_data;
        REG_CHARS_10_14: chars_10_14 <= cfg_data;
        REG_CHARS_15_19: chars_15_19 <= cfg_data;
        REG_CHARS_20_24: chars_20_24 <= cfg_data;
        REG_CHARS_25_29: chars_25_29 <= cfg_data;
        REG_CHARS_30_32: chars_30_32 <= cfg_data[REG6_W-1:0];
        default: ;
      endcase
    end
  end

  assign alphabet = {chars_30_32, chars_25_29, chars_20_24, chars_15_19,
                     chars_10_14, chars_5_9, chars_0_4};

  always_comb begin
    char_idx       = PAD_IDX;
    is_last        = 1'b0;
    stage_next     = ST_PAD;
    pads_left_next = pads_left;
    unique case (stage)
      ST_V0: begin
        char_idx   = {1'b0, cur.v0};
        is_last    = !cur.two && (cur.pads == 3'd0);
        stage_next = cur.two ? ST_V1 : ST_PAD;
      end
      ST_V1: begin
        char_idx = {1'b0, cur.v1};
        is_last  = (cur.pads == 3'd0);
      end
      default: begin
        is_last        = (pads_left == 3'd1);
        pads_left_next = pads_left - 3'd1;
      end
    endcase
  end

  assign load_out = cur_valid && (!out_valid || !out_stall);
  assign done     = load_out && is_last;
  assign q_pop    = q_not_empty && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      stage     <= ST_V0;
      pads_left <= 3'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      stage     <= ST_V0;
      pads_left <= q_head.pads;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (load_out) begin
      stage     <= stage_next;
      pads_left <= pads_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      code_char <= alphabet[{char_idx, 3'b000} +: 8];
      last_char <= is_last;
    end
  end

  a_pad_count: assert property (@(posedge clk) disable iff (rst)
    cur_valid && (stage == ST_PAD) |-> (pads_left != 3'd0))
    else $error("pad stage entered with no pads left");

  a_second_value: assert property (@(posedge clk) disable iff (rst)
    cur_valid && (stage == ST_V1) |-> cur.two)
    else $error("second value emitted for a one-value job");

  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> cur_valid && (stage == ST_V0))
    else $error("popped job not loaded");

endmodule

// ----- sim/tb_base32_stream_encoder_top.sv -----
// Self-checking testbench for base32_stream_encoder_top: drives data and finish
// words, predicts every output character and compares it with the block's output.
// Depends on bse_pkg and the encoder RTL only.
module tb_base32_stream_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bse_pkg::*;

  localparam int unsigned NUM_ALPHA_REGS = 7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned PAD_CHAR_IDX = 32;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  typedef logic [CFG_W-1:0] alphabet_t [NUM_ALPHA_REGS];

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 opcode = OP_ENCODE;
  logic [7:0]           data_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           code_char;
  logic                 last_char;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CHARS_0_4;
  logic [CFG_W-1:0]     cfg_data = '0;

  bit          gaps_on = 1'b1;
  int          err_count = 0;
  int unsigned cycle_count = 0;

  // Encoder state as predicted by the testbench.
  logic [2:0]       enc_phase = 3'd0;
  logic [4:0]       carry_bits = 5'd0;
  logic [CFG_W-1:0] alpha_regs [NUM_ALPHA_REGS];
  alphabet_t        std_set;
  char_t            expected_chars [$];

  base32_stream_encoder_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_char (code_char),
    .last_char (last_char),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_chars
    char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        err_count++;
        $error("code_char: expected none, got %h", code_char);
      end else begin
        want = expected_chars.pop_front();
        if (code_char !== want.ch) begin
          err_count++;
          $error("code_char: expected %h, got %h", want.ch, code_char);
        end
        if (last_char !== want.last) begin
          err_count++;
          $error("last_char: expected %b, got %b", want.last, last_char);
        end
      end
    end
  end

  function automatic logic [7:0] alpha_char(input int unsigned k);
    return alpha_regs[k / 5][8 * (k % 5) +: 8];
  endfunction

  task automatic predict_word(input logic op, input logic [7:0] b);
    int unsigned idx [$];
    int unsigned pads;
    char_t c;
    pads = 0;
    if (op == OP_ENCODE) begin
      case (enc_phase)
        3'd1: begin
          idx.push_back(32'(carry_bits | {3'b0, b[7:6]}));
          idx.push_back(32'(b[5:1]));
          carry_bits = {b[0], 4'b0};
          enc_phase = 3'd2;
        end
        3'd2: begin
          idx.push_back(32'(carry_bits | {1'b0, b[7:4]}));
          carry_bits = {b[3:0], 1'b0};
          enc_phase = 3'd3;
        end
        3'd3: begin
          idx.push_back(32'(carry_bits | {4'b0, b[7]}));
          idx.push_back(32'(b[6:2]));
          carry_bits = {b[1:0], 3'b0};
          enc_phase = 3'd4;
        end
        3'd4: begin
          idx.push_back(32'(carry_bits | {2'b0, b[7:5]}));
          idx.push_back(32'(b[4:0]));
          carry_bits = 5'd0;
          enc_phase = 3'd0;
        end
        default: begin
          idx.push_back(32'(b[7:3]));
          carry_bits = {b[2:0], 2'b0};
          enc_phase = 3'd1;
        end
      endcase
    end else begin
      case (enc_phase)
        3'd1: pads = 6;
        3'd2: pads = 4;
        3'd3: pads = 3;
        3'd4: pads = 1;
        default: pads = 0;
      endcase
      if (enc_phase >= 3'd1 && enc_phase <= 3'd4) begin
        idx.push_back(32'(carry_bits));
        repeat (pads) idx.push_back(PAD_CHAR_IDX);
      end
      carry_bits = 5'd0;
      enc_phase = 3'd0;
    end
    foreach (idx[i]) begin
      c.ch = alpha_char(idx[i]);
      c.last = (i == idx.size() - 1);
      expected_chars.push_back(c);
    end
  endtask

  task automatic send_word(input logic op, input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(op, b);
  endtask

  task automatic send_random_words(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(OP_FINISH, 8'($urandom));
      else send_word(OP_ENCODE, 8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_CHARS_30_32) alpha_regs[idx] = val & {{(CFG_W - REG6_W){1'b0}}, {REG6_W{1'b1}}};
    else if (idx != REG_UNUSED) alpha_regs[idx] = val;
  endtask

  // The unused index gets random data each time; the alphabet must not change.
  task automatic load_alphabet(input alphabet_t set);
    for (int i = 0; i < NUM_ALPHA_REGS; i++) write_reg(CFG_IDX_W'(i), set[i]);
    write_reg(REG_UNUSED, CFG_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Finish after zero to five data bytes hits every phase, including a
  // finish at the start of a group and one right after a full group.
  task automatic test_finish_each_phase();
    logic [7:0] patterns [15];
    int unsigned k;
    patterns = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h81, 8'h7E,
                 8'h01, 8'h80, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h55};
    k = 0;
    for (int n = 0; n <= 5; n++) begin
      for (int i = 0; i < n; i++) begin
        send_word(OP_ENCODE, patterns[k % 15]);
        k++;
      end
      send_word(OP_FINISH, 8'($urandom));
    end
  endtask

  task automatic test_alphabet_extremes();
    alphabet_t set;
    wait_drained();
    foreach (set[i]) set[i] = '0;
    load_alphabet(set);
    send_random_words(10);
    send_word(OP_FINISH, 8'h00);
    wait_drained();
    foreach (set[i]) set[i] = '1;
    load_alphabet(set);
    send_random_words(10);
    send_word(OP_FINISH, 8'hFF);
  endtask

  task automatic test_random_alphabets();
    alphabet_t set;
    for (int n = 0; n < 3; n++) begin
      wait_drained();
      foreach (set[i]) set[i] = CFG_W'({$urandom, $urandom});
      load_alphabet(set);
      send_random_words(90);
    end
  endtask

  task automatic test_drain_pause();
    send_random_words(35);
    wait_drained();
    send_random_words(35);
  endtask

  task automatic test_standard_alphabet_no_idle();
    wait_drained();
    gaps_on = 1'b0;
    load_alphabet(std_set);
    send_random_words(120);
  endtask

  initial begin
    std_set = '{RST_CHARS_0_4, RST_CHARS_5_9, RST_CHARS_10_14, RST_CHARS_15_19,
                RST_CHARS_20_24, RST_CHARS_25_29, CFG_W'(RST_CHARS_30_32)};
    alpha_regs = std_set;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_finish_each_phase();
    test_alphabet_extremes();
    test_random_alphabets();
    test_drain_pause();
    test_standard_alphabet_no_idle();

    wait_drained();
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
